// File: hw/rtl/quantum_asm_tokenizer_core_defines.svh
// Assertion macros used by the tokenizer RTL (the token queue).
`ifndef QUANTUM_ASM_TOKENIZER_CORE_DEFINES_SVH
`define QUANTUM_ASM_TOKENIZER_CORE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define QAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Assert that an expression always holds.
`define QAT_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/qat_pkg.sv
// Package with token types, codes and keyword matching for the tokenizer.
`default_nettype none
package qat_pkg;
	localparam int unsigned AddrBits = 20;
	localparam int unsigned KwChars = 8;
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrBits = 2;

	localparam logic [4:0] KindIdent = 5'd15;
	localparam logic [4:0] KindLbracket = 5'd16;
	localparam logic [4:0] KindInt = 5'd23;
	localparam logic [4:0] KindFloat = 5'd24;
	localparam logic [4:0] KindUnknown = 5'd25;
	localparam logic [4:0] KindEof = 5'd26;

	localparam logic [7:0] ChNl = 8'h0a;
	localparam logic [7:0] ChSlash = 8'h2f;
	localparam logic [7:0] ChUnder = 8'h5f;
	localparam logic [7:0] ChDot = 8'h2e;

	typedef enum logic [5:0] {
		MODE_IDLE = 6'b000001,
		MODE_SLASH = 6'b000010,
		MODE_COMMENT = 6'b000100,
		MODE_INT = 6'b001000,
		MODE_FRAC = 6'b010000,
		MODE_WORD = 6'b100000
	} mode_t;

	// Token as it leaves the front end; word tokens carry their text for matching.
	typedef struct packed {
		logic [4:0] kind;
		logic [AddrBits-1:0] start;
		logic [AddrBits:0] length;
		logic [AddrBits:0] line;
		logic last;
		logic is_word;
		logic [3:0] fill;
		logic [8*KwChars-1:0] text;
	} tok_t;

	typedef struct packed {
		logic v0;
		logic v1;
		tok_t t0;
		tok_t t1;
	} pair_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] c, output logic hit);
		logic [4:0] k;
		hit = 1'b1;
		k = KindLbracket;
		unique case (c)
			8'h5b: k = KindLbracket;
			8'h5d: k = KindLbracket + 5'd1;
			8'h28: k = KindLbracket + 5'd2;
			8'h29: k = KindLbracket + 5'd3;
			8'h3b: k = KindLbracket + 5'd4;
			8'h2c: k = KindLbracket + 5'd5;
			8'h2e: k = KindLbracket + 5'd6;
			default: hit = 1'b0;
		endcase
		return k;
	endfunction

	// Text is right-aligned: last character in the low byte.
	function automatic logic [4:0] classify(input logic [3:0] fill,
		input logic [8*KwChars-1:0] t);
		logic [4:0] k;
		k = KindIdent;
		priority case (fill)
			4'd8: if (t == 64'h4f50454e5141534d) k = 5'd0;
			4'd5: if (t[39:0] == 40'h7175626974) k = 5'd1;
			4'd4: if (t[31:0] == 32'h67617465) k = 5'd2;
			4'd3: begin
				if (t[23:0] == 24'h746467) k = 5'd6;
				else if (t[23:0] == 24'h736467) k = 5'd8;
			end
			4'd2: begin
				if (t[15:0] == 16'h6378) k = 5'd4;
				else if (t[15:0] == 16'h637a) k = 5'd12;
				else if (t[15:0] == 16'h727a) k = 5'd13;
			end
			4'd1: begin
				unique case (t[7:0])
					8'h68: k = 5'd3;
					8'h74: k = 5'd5;
					8'h73: k = 5'd7;
					8'h78: k = 5'd9;
					8'h79: k = 5'd10;
					8'h7a: k = 5'd11;
					8'h75: k = 5'd14;
					default: k = KindIdent;
				endcase
			end
			default: k = KindIdent;
		endcase
		return k;
	endfunction
endpackage
`default_nettype wire

// File: hw/rtl/qat_front.sv
// Scanner front end: consumes bytes and forms up to two raw tokens per item.
`default_nettype none
module qat_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [7:0] source_byte,
	input wire logic end_marker,
	input wire logic room,
	output logic in_stall,
	output logic push,
	output qat_pkg::pair_t pair
);
	localparam int unsigned AB = qat_pkg::AddrBits;
	localparam logic [AB:0] PosCap = {1'b1, {AB{1'b0}}};

	qat_pkg::mode_t mode_q, mode_d;
	logic [AB-1:0] start_q, start_d;
	logic [AB:0] pos_q, line_q, line_d;
	logic [63:0] wbuf_q, wbuf_d;
	logic [3:0] fill_q, fill_d;
	logic [AB-1:0] cur;
	logic [AB:0] len;
	logic acc, consumed, phit;
	logic [4:0] pk;
	qat_pkg::tok_t tf, ts, te;
	logic vf, vs;

	assign in_stall = !room;
	assign acc = in_valid && room;
	assign cur = pos_q[AB] ? {AB{1'b1}} : (pos_q[AB-1:0] == {AB{1'b1}} ? {AB{1'b1}} : pos_q[AB-1:0]);
	assign len = pos_q - {1'b0, start_q};

	always_comb begin
		mode_d = mode_q;
		start_d = start_q;
		line_d = line_q;
		wbuf_d = wbuf_q;
		fill_d = fill_q;
		consumed = 1'b0;
		vf = 1'b0;
		vs = 1'b0;
		tf = '0;
		ts = '0;
		te = '0;
		pk = qat_pkg::punct_kind(source_byte, phit);
		// Flushed pending token.
		tf.start = start_q;
		tf.length = len;
		tf.line = line_q;
		tf.is_word = mode_q == qat_pkg::MODE_WORD;
		tf.fill = fill_q;
		tf.text = wbuf_q;
		unique case (mode_q)
			qat_pkg::MODE_SLASH: begin tf.kind = qat_pkg::KindUnknown; tf.length = 21'd1; end
			qat_pkg::MODE_INT: tf.kind = qat_pkg::KindInt;
			qat_pkg::MODE_FRAC: tf.kind = qat_pkg::KindFloat;
			default: tf.kind = qat_pkg::KindIdent;
		endcase
		if (end_marker) begin
			vf = mode_q == qat_pkg::MODE_SLASH || mode_q == qat_pkg::MODE_INT
				|| mode_q == qat_pkg::MODE_FRAC || mode_q == qat_pkg::MODE_WORD;
			vs = 1'b1;
			ts.kind = qat_pkg::KindEof;
			ts.start = cur;
			ts.line = line_q;
		end else begin
			unique case (mode_q)
				qat_pkg::MODE_SLASH: if (source_byte == qat_pkg::ChSlash) begin
					mode_d = qat_pkg::MODE_COMMENT; consumed = 1'b1;
				end
				qat_pkg::MODE_COMMENT: if (source_byte == qat_pkg::ChNl) mode_d = qat_pkg::MODE_IDLE;
					else consumed = 1'b1;
				qat_pkg::MODE_INT: if (qat_pkg::is_digit(source_byte)) consumed = 1'b1;
					else if (source_byte == qat_pkg::ChDot) begin
						mode_d = qat_pkg::MODE_FRAC; consumed = 1'b1;
					end
				qat_pkg::MODE_FRAC: if (qat_pkg::is_digit(source_byte)) consumed = 1'b1;
				qat_pkg::MODE_WORD: if (qat_pkg::is_alpha(source_byte)
						|| qat_pkg::is_digit(source_byte) || source_byte == qat_pkg::ChUnder) begin
					consumed = 1'b1;
					if (fill_q < 4'd8) begin
						wbuf_d = {wbuf_q[55:0], source_byte};
						fill_d = fill_q + 4'd1;
					end else fill_d = 4'd9;
				end
				default: ;
			endcase
			if (!consumed) begin
				vf = mode_q == qat_pkg::MODE_SLASH || mode_q == qat_pkg::MODE_INT
					|| mode_q == qat_pkg::MODE_FRAC || mode_q == qat_pkg::MODE_WORD;
				mode_d = qat_pkg::MODE_IDLE;
				ts.start = cur;
				ts.length = 21'd1;
				ts.line = line_q;
				ts.kind = qat_pkg::KindUnknown;
				if (source_byte == qat_pkg::ChNl) begin
					if (line_q < PosCap) line_d = line_q + 1'b1;
				end else if (qat_pkg::is_space(source_byte)) begin
				end else if (source_byte == qat_pkg::ChSlash) begin
					mode_d = qat_pkg::MODE_SLASH; start_d = cur;
				end else if (phit) begin
					vs = 1'b1; ts.kind = pk;
				end else if (qat_pkg::is_digit(source_byte)) begin
					mode_d = qat_pkg::MODE_INT; start_d = cur;
				end else if (qat_pkg::is_alpha(source_byte) || source_byte == qat_pkg::ChUnder) begin
					mode_d = qat_pkg::MODE_WORD; start_d = cur;
					wbuf_d = {56'd0, source_byte}; fill_d = 4'd1;
				end else vs = 1'b1;
			end
		end
		// Mark the last token of this item.
		tf.last = vf && !vs;
		ts.last = vs;
		pair.v0 = vf || vs;
		pair.v1 = vf && vs;
		pair.t0 = vf ? tf : ts;
		pair.t1 = vf ? ts : te;
	end

	assign push = acc && pair.v0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= qat_pkg::MODE_IDLE;
			start_q <= '0;
			pos_q <= '0;
			line_q <= {{AB{1'b0}}, 1'b1};
			wbuf_q <= '0;
			fill_q <= '0;
		end else if (acc) begin
			if (end_marker) begin
				mode_q <= qat_pkg::MODE_IDLE;
				start_q <= '0;
				pos_q <= '0;
				line_q <= {{AB{1'b0}}, 1'b1};
				wbuf_q <= '0;
				fill_q <= '0;
			end else begin
				mode_q <= mode_d;
				start_q <= start_d;
				line_q <= line_d;
				wbuf_q <= wbuf_d;
				fill_q <= fill_d;
				if (!pos_q[AB]) pos_q <= pos_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/qat_queue.sv
// Token queue between front and back end; takes up to two tokens a cycle while it has room.
`default_nettype none
`include "quantum_asm_tokenizer_core_defines.svh"
module qat_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire qat_pkg::pair_t pair,
	output logic room,
	input wire logic pop,
	output logic nonempty,
	output qat_pkg::tok_t head
);
	localparam int unsigned PB = qat_pkg::QPtrBits;
	qat_pkg::tok_t mem_q [qat_pkg::QDepth];
	logic [PB-1:0] wp_q, rp_q;
	logic [PB:0] cnt_q, cnt_next;
	logic [PB:0] nin;

	assign nin = push ? (pair.v1 ? 3'd2 : 3'd1) : 3'd0;
	// Room for two whatever this cycle's pop does.
	assign room = cnt_q <= 3'd2;
	assign nonempty = cnt_q != 3'd0;
	assign head = mem_q[rp_q];
	assign cnt_next = cnt_q + nin - {2'd0, pop};

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= pair.t0;
			if (pair.v1) mem_q[wp_q + 1'b1] <= pair.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + nin[PB-1:0];
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_next;
		end
	end

	`QAT_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, nonempty)
	`QAT_ASSERT_IMP(a_no_overflow, clk, arst_n, push, room)
	`QAT_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= 3'd4)
endmodule
`default_nettype wire

// File: hw/rtl/qat_back.sv
// Back end: resolves keywords and drives the output register.
`default_nettype none
module qat_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic nonempty,
	input wire qat_pkg::tok_t head,
	output logic pop,
	input wire logic out_stall,
	output logic out_valid,
	output logic [4:0] token_kind,
	output logic [19:0] token_start,
	output logic [20:0] token_length,
	output logic [20:0] token_line,
	output logic last_of_run
);
	logic load;
	assign load = !out_valid || !out_stall;
	assign pop = nonempty && load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (load) out_valid <= nonempty;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			token_kind <= head.is_word ? qat_pkg::classify(head.fill, head.text) : head.kind;
			token_start <= head.start;
			token_length <= head.length;
			token_line <= head.line;
			last_of_run <= head.last;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/quantum_asm_tokenizer_core.sv
// Top level of the source tokenizer.
`default_nettype none
// Tokenizer: takes one source byte per item and emits tokens (kind, start, length, line).
// An item is taken every cycle while the four-entry token queue has room for two tokens;
// one token leaves per cycle while the output is not stalled, so a byte yielding two tokens needs two output transfers.
// The front end scans bytes, the queue decouples it from the back end, which matches
// keywords and holds the output register. An end item flushes, emits EOF and resets.
module quantum_asm_tokenizer_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] source_byte,
	input wire logic end_marker,
	output logic out_valid,
	input wire logic out_stall,
	output logic [4:0] token_kind,
	output logic [19:0] token_start,
	output logic [20:0] token_length,
	output logic [20:0] token_line,
	output logic last_of_run
);
	logic room, push, pop, nonempty;
	qat_pkg::pair_t pair;
	qat_pkg::tok_t head;

	qat_front u_front (.clk, .arst_n, .in_valid, .source_byte, .end_marker, .room,
		.in_stall, .push, .pair);
	qat_queue u_queue (.clk, .arst_n, .push, .pair, .room, .pop, .nonempty, .head);
	qat_back u_back (.clk, .arst_n, .nonempty, .head, .pop, .out_stall, .out_valid,
		.token_kind, .token_start, .token_length, .token_line, .last_of_run);
endmodule
`default_nettype wire
